/* src/plf_pkg.sv */
`default_nettype none

package plf_pkg;

  // Configuration register indexes, in port order.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_BLACK_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_POWER      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_RATIO      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_RATIO     = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [9:0]  RST_BLACK_THRESHOLD = 10'd650;
  localparam logic [11:0] RST_GAIN_P          = 12'd400;
  localparam logic [11:0] RST_GAIN_I          = 12'd0;
  localparam logic [11:0] RST_GAIN_D          = 12'd240;
  localparam logic [7:0]  RST_BASE_POWER      = 8'd100;
  localparam logic [8:0]  RST_LEFT_RATIO      = 9'd253;
  localparam logic [8:0]  RST_RIGHT_RATIO     = 9'd256;

  // Integral clamp limit and power ceiling.
  localparam logic signed [4:0] SUM_LIMIT = 5'sd5;
  localparam logic [7:0] POWER_MAX = 8'd255;

  typedef struct packed {
    logic [9:0]  black_threshold;
    logic [11:0] gain_p;
    logic [11:0] gain_i;
    logic [11:0] gain_d;
    logic [7:0]  base_power;
    logic [8:0]  left_ratio;
    logic [8:0]  right_ratio;
  } cfg_t;

  // Microprogram addresses.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_WAIT      = 4'd0;
  localparam logic [STEP_W-1:0] ST_CLASSIFY  = 4'd1;
  localparam logic [STEP_W-1:0] ST_MUL_P     = 4'd2;
  localparam logic [STEP_W-1:0] ST_MUL_I     = 4'd3;
  localparam logic [STEP_W-1:0] ST_MUL_D     = 4'd4;
  localparam logic [STEP_W-1:0] ST_ACC_D     = 4'd5;
  localparam logic [STEP_W-1:0] ST_SAT_L     = 4'd6;
  localparam logic [STEP_W-1:0] ST_MUL_RL    = 4'd7;
  localparam logic [STEP_W-1:0] ST_TRIM_L    = 4'd8;
  localparam logic [STEP_W-1:0] ST_MUL_RR    = 4'd9;
  localparam logic [STEP_W-1:0] ST_TRIM_R    = 4'd10;
  localparam logic [STEP_W-1:0] ST_EMIT      = 4'd11;
  localparam logic [STEP_W-1:0] ST_EMIT_X    = 4'd12;

  typedef enum logic [1:0] {
    A_ERR,
    A_SUM,
    A_DIFF,
    A_POW
  } mul_a_t;

  typedef enum logic [2:0] {
    B_GP,
    B_GI,
    B_GD,
    B_RL,
    B_RR
  } mul_b_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_ADD
  } acc_op_t;

  // One microcode word.
  typedef struct packed {
    logic              wait_in;
    logic              classify;
    logic              mul_en;
    mul_a_t            mul_a;
    mul_b_t            mul_b;
    acc_op_t           acc_op;
    logic              sat_en;
    logic              sat_neg;
    logic              trim_l;
    logic              trim_r;
    logic              emit;
    logic              emit_x;
    logic              goto_en;
    logic [STEP_W-1:0] target;
  } ctl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic both_black;
    logic out_busy;
  } stat_t;

  // The control store.
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = '0;
    unique case (step)
      ST_WAIT: begin
        w.wait_in = 1'b1;
      end
      ST_CLASSIFY: begin
        w.classify = 1'b1;
        w.target   = ST_EMIT_X;
      end
      ST_MUL_P: begin
        w.mul_en = 1'b1;
        w.mul_a  = A_ERR;
        w.mul_b  = B_GP;
        w.acc_op = ACC_CLR;
      end
      ST_MUL_I: begin
        w.mul_en = 1'b1;
        w.mul_a  = A_SUM;
        w.mul_b  = B_GI;
        w.acc_op = ACC_ADD;
      end
      ST_MUL_D: begin
        w.mul_en = 1'b1;
        w.mul_a  = A_DIFF;
        w.mul_b  = B_GD;
        w.acc_op = ACC_ADD;
      end
      ST_ACC_D: begin
        w.acc_op = ACC_ADD;
      end
      ST_SAT_L: begin
        w.sat_en = 1'b1;
      end
      ST_MUL_RL: begin
        w.mul_en = 1'b1;
        w.mul_a  = A_POW;
        w.mul_b  = B_RL;
      end
      ST_TRIM_L: begin
        w.trim_l  = 1'b1;
        w.sat_en  = 1'b1;
        w.sat_neg = 1'b1;
      end
      ST_MUL_RR: begin
        w.mul_en = 1'b1;
        w.mul_a  = A_POW;
        w.mul_b  = B_RR;
      end
      ST_TRIM_R: begin
        w.trim_r = 1'b1;
      end
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.target = ST_WAIT;
      end
      ST_EMIT_X: begin
        w.emit_x = 1'b1;
        w.target = ST_WAIT;
      end
      default: begin
        w.goto_en = 1'b1;
        w.target  = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* src/plf_seq.sv */
`default_nettype none

module plf_seq import plf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire stat_t stat,
  output ctl_t       ctl
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;

  assign ctl = ucode(step_r);

  // Default is the next word; waits hold the counter, branches load the target.
  always_comb begin
    step_nxt = step_r + 1'b1;
    if (ctl.wait_in) begin
      if (!in_valid) begin
        step_nxt = step_r;
      end
    end else if (ctl.classify) begin
      if (stat.both_black) begin
        step_nxt = ctl.target;
      end
    end else if (ctl.emit || ctl.emit_x) begin
      step_nxt = stat.out_busy ? step_r : ctl.target;
    end else if (ctl.goto_en) begin
      step_nxt = ctl.target;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/plf_dp.sv */
`default_nettype none

module plf_dp import plf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctl_t              ctl,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  input  wire logic [9:0]        in_left_sample,
  input  wire logic [9:0]        in_right_sample,
  output stat_t                  stat,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [7:0]             out_left_power,
  output logic [7:0]             out_right_power,
  output logic signed [1:0]      out_track_error,
  output logic                   out_intersection
);

  logic [9:0]         ls_r, rs_r;
  logic signed [1:0]  err_r, last_r;
  logic signed [3:0]  sum_r;
  logic signed [2:0]  diff_r;
  logic signed [22:0] prod_r;
  logic signed [17:0] acc_r;
  logic [7:0]         pow_r, left_r, right_r;
  logic               out_valid_r;
  logic [7:0]         out_left_r, out_right_r;
  logic signed [1:0]  out_err_r;
  logic               out_x_r;

  logic               lb, rb;
  logic signed [1:0]  err_cls;
  logic signed [4:0]  sum_wide;
  logic signed [3:0]  sum_clamped;
  logic signed [2:0]  diff_cls;
  logic signed [9:0]  mul_a;
  logic signed [12:0] mul_b;
  logic signed [22:0] product;
  logic signed [17:0] base16, side_sum;
  logic [7:0]         sat_pow;
  logic [8:0]         trim_raw;
  logic [7:0]         trimmed;
  logic               emit_fire;

  assign lb = ls_r >= cfg.black_threshold;
  assign rb = rs_r >= cfg.black_threshold;

  always_comb begin
    if (lb) begin
      err_cls = -2'sd1;
    end else if (rb) begin
      err_cls = 2'sd1;
    end else begin
      err_cls = 2'sd0;
    end
  end

  assign sum_wide = {sum_r[3], sum_r} + {{3{err_cls[1]}}, err_cls};

  always_comb begin
    if (sum_wide > SUM_LIMIT) begin
      sum_clamped = SUM_LIMIT[3:0];
    end else if (sum_wide < -SUM_LIMIT) begin
      sum_clamped = 4'(-SUM_LIMIT);
    end else begin
      sum_clamped = sum_wide[3:0];
    end
  end

  assign diff_cls = {err_cls[1], err_cls} - {last_r[1], last_r};

  // Shared multiplier operands.
  always_comb begin
    case (ctl.mul_a)
      A_ERR:   mul_a = {{8{err_r[1]}}, err_r};
      A_SUM:   mul_a = {{6{sum_r[3]}}, sum_r};
      A_DIFF:  mul_a = {{7{diff_r[2]}}, diff_r};
      A_POW:   mul_a = {2'b00, pow_r};
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctl.mul_b)
      B_GP:    mul_b = {1'b0, cfg.gain_p};
      B_GI:    mul_b = {1'b0, cfg.gain_i};
      B_GD:    mul_b = {1'b0, cfg.gain_d};
      B_RL:    mul_b = {4'b0000, cfg.left_ratio};
      B_RR:    mul_b = {4'b0000, cfg.right_ratio};
      default: mul_b = '0;
    endcase
  end

  assign product = mul_a * mul_b;

  // Side sum in sixteenths of a power step, then floor and saturate.
  assign base16   = $signed({6'b000000, cfg.base_power, 4'b0000});
  assign side_sum = ctl.sat_neg ? (base16 - acc_r) : (base16 + acc_r);

  always_comb begin
    if (side_sum[17]) begin
      sat_pow = 8'd0;
    end else if (|side_sum[16:12]) begin
      sat_pow = POWER_MAX;
    end else begin
      sat_pow = side_sum[11:4];
    end
  end

  assign trim_raw = prod_r[16:8];
  assign trimmed  = trim_raw[8] ? POWER_MAX : trim_raw[7:0];

  assign emit_fire = (ctl.emit || ctl.emit_x) && !stat.out_busy;

  assign stat.both_black = lb && rb;
  assign stat.out_busy   = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (ctl.wait_in && in_valid) begin
      ls_r <= in_left_sample;
      rs_r <= in_right_sample;
    end
    if (ctl.classify) begin
      diff_r <= diff_cls;
    end
    if (ctl.mul_en) begin
      prod_r <= product;
    end
    case (ctl.acc_op)
      ACC_CLR: acc_r <= '0;
      ACC_ADD: acc_r <= acc_r + prod_r[17:0];
      default: acc_r <= acc_r;
    endcase
    if (ctl.sat_en) begin
      pow_r <= sat_pow;
    end
    if (ctl.trim_l) begin
      left_r <= trimmed;
    end
    if (ctl.trim_r) begin
      right_r <= trimmed;
    end
    if (emit_fire) begin
      out_left_r  <= ctl.emit ? left_r : 8'd0;
      out_right_r <= ctl.emit ? right_r : 8'd0;
      out_err_r   <= ctl.emit ? err_r : 2'sd0;
      out_x_r     <= ctl.emit_x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r       <= '0;
      last_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.classify && !stat.both_black) begin
        err_r  <= err_cls;
        last_r <= err_cls;
        sum_r  <= sum_clamped;
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_power   = out_left_r;
  assign out_right_power  = out_right_r;
  assign out_track_error  = out_err_r;
  assign out_intersection = out_x_r;

endmodule

`default_nettype wire

/* src/pid_line_follower.sv */
// Two-sensor PID line follower. Each input transfer carries one pair of
// 10-bit reflectance samples; each produces exactly one result transfer with
// the trimmed left and right motor powers, the tracking error (-1, 0 or +1)
// and an intersection flag. A small microcoded sequencer steps a datapath
// with one shared signed multiplier through the P, I and D products and the
// two per-side trim products, five passes through the multiplier in all. A
// normal sample runs from its transfer through the classify, multiply,
// accumulate, saturate and trim steps to the emit step, which loads the
// result into the output register; only then does the sequencer return to
// its wait step and accept the next sample. An intersection (both sensors
// black) goes straight from the classify step to its own emit step. The
// output register lets the next sample be taken while a result still waits;
// the sequencer stalls only at its final step if the previous result has not
// been transferred yet. Configuration writes land immediately and must be
// made while no sample is in flight.

`default_nettype none

module pid_line_follower import plf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [9:0]            in_left_sample,
  input  wire logic [9:0]            in_right_sample,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_left_power,
  output logic [7:0]                 out_right_power,
  output logic signed [1:0]          out_track_error,
  output logic                       out_intersection
);

  cfg_t  cfg_r;
  ctl_t  ctl;
  stat_t stat;

  // Configuration registers; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.black_threshold <= RST_BLACK_THRESHOLD;
      cfg_r.gain_p          <= RST_GAIN_P;
      cfg_r.gain_i          <= RST_GAIN_I;
      cfg_r.gain_d          <= RST_GAIN_D;
      cfg_r.base_power      <= RST_BASE_POWER;
      cfg_r.left_ratio      <= RST_LEFT_RATIO;
      cfg_r.right_ratio     <= RST_RIGHT_RATIO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLACK_THRESHOLD: cfg_r.black_threshold <= cfg_wdata[9:0];
        REG_GAIN_P:          cfg_r.gain_p          <= cfg_wdata;
        REG_GAIN_I:          cfg_r.gain_i          <= cfg_wdata;
        REG_GAIN_D:          cfg_r.gain_d          <= cfg_wdata;
        REG_BASE_POWER:      cfg_r.base_power      <= cfg_wdata[7:0];
        REG_LEFT_RATIO:      cfg_r.left_ratio      <= cfg_wdata[8:0];
        REG_RIGHT_RATIO:     cfg_r.right_ratio     <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // The sequencer only opens the input channel on its wait step.
  assign in_ready = ctl.wait_in;

  plf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  plf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_left_sample   (in_left_sample),
    .in_right_sample  (in_right_sample),
    .stat             (stat),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_left_power   (out_left_power),
    .out_right_power  (out_right_power),
    .out_track_error  (out_track_error),
    .out_intersection (out_intersection)
  );

  // An intersection result always carries zero power and zero error.
  a_isect_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_intersection) |->
      (out_left_power == 8'd0 && out_right_power == 8'd0 && out_track_error == 2'sd0))
    else $error("intersection result with nonzero payload");

  // The error code -2 is never produced.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_track_error != -2'sd2))
    else $error("invalid track error code");

  // One sample at a time: the input closes right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input reopened directly after a transfer");

endmodule

`default_nettype wire

/* tb/motor_command_checker.sv */
`timescale 1ns / 100ps

module motor_command_checker import plf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [9:0]            in_left_sample,
  input  logic [9:0]            in_right_sample,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_left_power,
  input  logic [7:0]            out_right_power,
  input  logic signed [1:0]     out_track_error,
  input  logic                  out_intersection,
  output int                    fail_count,
  output int                    pending_results
);

  typedef struct packed {
    logic [7:0]        left_power;
    logic [7:0]        right_power;
    logic signed [1:0] track_error;
    logic              intersection;
  } drive_t;

  cfg_t              settings;
  logic signed [3:0] err_sum;
  logic signed [1:0] prev_err;
  drive_t            drives_due[$];
  int                errors = 0;

  // Saturate the 1/16-unit side sum to 0..255, then trim and saturate again.
  function automatic logic [7:0] trimmed_power(input int sum16, input logic [8:0] ratio);
    int p;
    int t;
    p = (sum16 < 0) ? 0 : sum16 / 16;
    if (p > 255) p = 255;
    t = (p * int'(ratio)) >> 8;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  // Expected motor command for one sample pair; advances the PID state.
  function automatic drive_t forecast_drive(input logic [9:0] ls, input logic [9:0] rs);
    drive_t d;
    logic   lb;
    logic   rb;
    int     e;
    int     total;
    int     pid;
    int     base16;
    d  = '0;
    lb = (ls >= settings.black_threshold);
    rb = (rs >= settings.black_threshold);
    if (lb && rb) begin
      d.intersection = 1'b1;
      return d;
    end
    e = lb ? -1 : (rb ? 1 : 0);
    total = int'(err_sum);
    total = total + e;
    if (total > 5) total = 5;
    if (total < -5) total = -5;
    pid = int'(settings.gain_p) * e + int'(settings.gain_i) * total
        + int'(settings.gain_d) * (e - int'(prev_err));
    err_sum  = total[3:0];
    prev_err = e[1:0];
    base16 = int'(settings.base_power) * 16;
    d.left_power  = trimmed_power(base16 + pid, settings.left_ratio);
    d.right_power = trimmed_power(base16 - pid, settings.right_ratio);
    d.track_error = e[1:0];
    return d;
  endfunction

  always @(posedge clk) begin
    drive_t got;
    drive_t want;
    if (!rst_n) begin
      settings.black_threshold = RST_BLACK_THRESHOLD;
      settings.gain_p          = RST_GAIN_P;
      settings.gain_i          = RST_GAIN_I;
      settings.gain_d          = RST_GAIN_D;
      settings.base_power      = RST_BASE_POWER;
      settings.left_ratio      = RST_LEFT_RATIO;
      settings.right_ratio     = RST_RIGHT_RATIO;
      err_sum  = '0;
      prev_err = '0;
      drives_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BLACK_THRESHOLD: settings.black_threshold = cfg_wdata[9:0];
          REG_GAIN_P:          settings.gain_p          = cfg_wdata[11:0];
          REG_GAIN_I:          settings.gain_i          = cfg_wdata[11:0];
          REG_GAIN_D:          settings.gain_d          = cfg_wdata[11:0];
          REG_BASE_POWER:      settings.base_power      = cfg_wdata[7:0];
          REG_LEFT_RATIO:      settings.left_ratio      = cfg_wdata[8:0];
          REG_RIGHT_RATIO:     settings.right_ratio     = cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        drives_due.push_back(forecast_drive(in_left_sample, in_right_sample));
      if (out_valid && out_ready) begin
        got.left_power   = out_left_power;
        got.right_power  = out_right_power;
        got.track_error  = out_track_error;
        got.intersection = out_intersection;
        if (drives_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display({"%0t: result transfer with nothing expected: ",
                      "left %0d right %0d err %0d x %0b"},
                     $time, got.left_power, got.right_power, got.track_error,
                     got.intersection);
        end else begin
          want = drives_due.pop_front();
          if (got.left_power !== want.left_power || got.right_power !== want.right_power ||
              got.track_error !== want.track_error ||
              got.intersection !== want.intersection) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: mismatch: expected left %0d right %0d err %0d x %0b, ",
                        "got left %0d right %0d err %0d x %0b"},
                       $time, want.left_power, want.right_power, want.track_error,
                       want.intersection, got.left_power, got.right_power,
                       got.track_error, got.intersection);
          end
        end
      end
    end
    fail_count      <= errors;
    pending_results <= drives_due.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import plf_pkg::*;

  // Cycles without any transfer before the run is declared hung. The longest
  // legitimate quiet stretch is the deliberate receiver hold-off plus a few
  // sample computations, so this leaves a wide margin.
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS   = 60;
  localparam int RANDOM_PHASES = 8;

  // Index past the last register; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Shapes of sample pairs produced by the random generator.
  localparam int PAIR_WHITE = 0;
  localparam int PAIR_LEFT  = 1;
  localparam int PAIR_RIGHT = 2;
  localparam int PAIR_CROSS = 3;
  localparam int PAIR_NOISE = 4;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [9:0]            in_left_sample = '0;
  logic [9:0]            in_right_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_left_power;
  logic [7:0]            out_right_power;
  logic signed [1:0]     out_track_error;
  logic                  out_intersection;

  int fail_count;
  int pending_results;

  // Traffic shaping. tx_idle_pct is used only by the stimulus process;
  // rx_stall_pct and rx_hold_req are written with nonblocking assignments
  // because the receiver process reads them at the same clock edge.
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  logic rx_hold_req = 1'b0;

  // Current black threshold, kept so that generated samples land on the
  // intended side of it.
  logic [9:0] thr_now = RST_BLACK_THRESHOLD;
  int         pair_kind = PAIR_WHITE;

  always #2 clk = ~clk;

  pid_line_follower DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_left_sample   (in_left_sample),
    .in_right_sample  (in_right_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_power   (out_left_power),
    .out_right_power  (out_right_power),
    .out_track_error  (out_track_error),
    .out_intersection (out_intersection)
  );

  motor_command_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_left_sample   (in_left_sample),
    .in_right_sample  (in_right_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_power   (out_left_power),
    .out_right_power  (out_right_power),
    .out_track_error  (out_track_error),
    .out_intersection (out_intersection),
    .fail_count       (fail_count),
    .pending_results  (pending_results)
  );

  // Receiver. It normally stalls at random with the current percentage. A
  // rising request starts one long hold-off, counted here, during which the
  // output register fills and the block stops taking samples.
  int hold_left = 0;
  bit hold_armed = 1'b0;

  always @(posedge clk) begin
    if (!rx_hold_req) begin
      hold_armed = 1'b1;
    end else if (hold_armed) begin
      hold_left  = HOLD_CYCLES;
      hold_armed = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: any transfer on either channel resets the quiet count.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("FAIL pid_line_follower");
      $finish;
    end
  end

  // One register write. The enable drops for a cycle after each write so
  // that it is never lowered and raised in the same time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Writes every register. Bits above the width of the threshold, base power
  // and ratio registers carry junk, which the block must drop, and the unused index gets a write as well.
  task automatic apply_settings(input logic [9:0] thr, input logic [11:0] gp,
                                input logic [11:0] gi, input logic [11:0] gd,
                                input logic [7:0] bp, input logic [8:0] lr,
                                input logic [8:0] rr);
    logic [11:0] junk;
    junk = 12'($urandom_range(4095));
    write_reg(REG_BLACK_THRESHOLD, {junk[11:10], thr});
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_BASE_POWER, {junk[7:4], bp});
    write_reg(REG_LEFT_RATIO, {junk[2:0], lr});
    write_reg(REG_RIGHT_RATIO, {junk[11:9], rr});
    write_reg(REG_UNUSED, junk);
    thr_now = thr;
  endtask

  // Gains: mostly moderate so that the powers are not always pinned, with
  // the extremes showing up regularly.
  function automatic logic [11:0] pick_gain();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 12'd0;
    if (roll < 20) return 12'd4095;
    if (roll < 70) return 12'($urandom_range(400));
    return 12'($urandom_range(4095));
  endfunction

  task automatic random_settings();
    apply_settings(10'($urandom_range(1023, 1)), pick_gain(), pick_gain(), pick_gain(),
                   8'($urandom_range(255)), 9'($urandom_range(511)),
                   9'($urandom_range(511)));
  endtask

  function automatic logic [9:0] white_level();
    if (thr_now == 0) return 10'd0;
    return 10'($urandom_range(int'(thr_now) - 1, 0));
  endfunction

  function automatic logic [9:0] black_level();
    return 10'($urandom_range(1023, int'(thr_now)));
  endfunction

  // Sample pairs tend to repeat their shape, which gives runs of one-sided
  // error long enough to drive the integral into its clamp in both
  // directions. A share of pairs is plain noise over the full range.
  task automatic next_pair(output logic [9:0] l, output logic [9:0] r);
    int roll;
    if ($urandom_range(99) >= 60) begin
      roll = $urandom_range(99);
      if (roll < 25)      pair_kind = PAIR_WHITE;
      else if (roll < 50) pair_kind = PAIR_LEFT;
      else if (roll < 75) pair_kind = PAIR_RIGHT;
      else if (roll < 85) pair_kind = PAIR_CROSS;
      else                pair_kind = PAIR_NOISE;
    end
    case (pair_kind)
      PAIR_WHITE: begin
        l = white_level();
        r = white_level();
      end
      PAIR_LEFT: begin
        l = black_level();
        r = white_level();
      end
      PAIR_RIGHT: begin
        l = white_level();
        r = black_level();
      end
      PAIR_CROSS: begin
        l = black_level();
        r = black_level();
      end
      default: begin
        l = 10'($urandom_range(1023));
        r = 10'($urandom_range(1023));
      end
    endcase
  endtask

  // Offers one sample pair and returns right after the edge that takes it.
  // Valid stays high into the next call unless that call opens a gap. Ready
  // is looked at on the falling edge, where it already holds the value that
  // the next rising edge will see.
  task automatic send_sample(input logic [9:0] l, input logic [9:0] r);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_left_sample  <= l;
    in_right_sample <= r;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // The sender pauses until every expected result has been transferred.
  // Every sample yields a result, so the block is idle once this returns.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    @(posedge clk);
  endtask

  initial begin
    int phase;
    logic [9:0] l;
    logic [9:0] r;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: white, each one-sided case, a crossing, and both
    // sides exactly at and just below the threshold.
    send_sample(10'd0, 10'd0);
    send_sample(10'd1023, 10'd0);
    send_sample(10'd0, 10'd1023);
    send_sample(10'd1023, 10'd1023);
    send_sample(10'd650, 10'd649);
    send_sample(10'd649, 10'd650);
    send_sample(10'd649, 10'd649);
    send_sample(10'd650, 10'd650);
    wait_drained();

    // Everything at its maximum. Long one-sided runs push the integral to
    // both clamps, and with ratios above unity the trimmed power overflows
    // and has to saturate.
    apply_settings(10'd1023, 12'd4095, 12'd4095, 12'd4095, 8'd255, 9'd511, 9'd511);
    repeat (6) send_sample(10'd1023, 10'd0);
    repeat (6) send_sample(10'd0, 10'd1023);
    send_sample(10'd1022, 10'd1022);
    send_sample(10'd1023, 10'd1023);
    wait_drained();

    // Everything at zero: a zero threshold makes every pair a crossing.
    apply_settings(10'd0, 12'd0, 12'd0, 12'd0, 8'd0, 9'd0, 9'd0);
    send_sample(10'd0, 10'd0);
    send_sample(10'd1023, 10'd0);
    wait_drained();

    // Back pressure: the receiver holds off for a long stretch while the
    // sender keeps offering, so the output register fills and the block
    // stops accepting samples.
    random_settings();
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    rx_hold_req <= 1'b1;
    repeat (12) begin
      next_pair(l, r);
      send_sample(l, r);
    end
    rx_hold_req <= 1'b0;

    // Random phases, each with fresh settings and one of the idling modes:
    // none, sender gaps, receiver stalls, or both.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      random_settings();
      case (phase % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct = 59;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 59;
        end
        default: begin
          tx_idle_pct = 35;
          rx_stall_pct <= 35;
        end
      endcase
      repeat (PHASE_ITEMS) begin
        next_pair(l, r);
        send_sample(l, r);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("PASS pid_line_follower");
    else
      $display("FAIL pid_line_follower");
    $finish;
  end

endmodule

/* filelist.f */
src/plf_pkg.sv
src/plf_seq.sv
src/plf_dp.sv
src/pid_line_follower.sv
tb/motor_command_checker.sv
tb/testbench.sv
